>>> src/dqp_pkg.sv
// Shared types and constants for the DNS query parser.
package dqp_pkg;

	typedef enum logic [2:0] {
		KIND_HDR_OK   = 3'd0,
		KIND_NAME_CHR = 3'd1,
		KIND_Q_END    = 3'd2,
		KIND_HDR_REJ  = 3'd3,
		KIND_TRUNC    = 3'd4,
		KIND_DONE     = 3'd5
	} kind_t;

	typedef enum logic [2:0] {
		PH_HEADER   = 3'd0,
		PH_NAME_LEN = 3'd1,
		PH_NAME_CHR = 3'd2,
		PH_TYPECLS  = 3'd3,
		PH_FINISHED = 3'd4,
		PH_REJECTED = 3'd5
	} phase_t;

	localparam int unsigned HDR_WORDS = 5;
	localparam logic [3:0] HDR_LAST_POS = 4'd11;
	localparam logic [3:0] TC_LAST_POS = 4'd3;
	localparam logic [7:0] DOT_CHAR = 8'h2E;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} beat_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] ident;
		logic [15:0] count;
		logic        is_response;
		logic [3:0]  op_code;
		logic        authoritative;
		logic        truncated_flag;
		logic        recursion_desired;
		logic        recursion_available;
		logic [3:0]  response_code;
		logic [7:0]  character;
		logic        final_res;
	} res_t;

endpackage

>>> src/dqp_if.sv
// Byte and result channel interfaces of the DNS query parser.
interface dqp_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface dqp_res_if;
	logic                valid;
	logic                ready;
	dqp_pkg::kind_t      kind;
	logic [15:0]         ident;
	logic [15:0]         count;
	logic                is_response;
	logic [3:0]          op_code;
	logic                authoritative;
	logic                truncated_flag;
	logic                recursion_desired;
	logic                recursion_available;
	logic [3:0]          response_code;
	logic [7:0]          character;
	logic                final_res;

	modport source (
		output valid, output kind, output ident, output count, output is_response,
		output op_code, output authoritative, output truncated_flag,
		output recursion_desired, output recursion_available, output response_code,
		output character, output final_res, input ready
	);
	modport sink (
		input valid, input kind, input ident, input count, input is_response,
		input op_code, input authoritative, input truncated_flag,
		input recursion_desired, input recursion_available, input response_code,
		input character, input final_res, output ready
	);
endinterface

>>> src/dqp_in_stage.sv
// Input register stage holding one received byte beat.
module dqp_in_stage (
	input  logic               clk,
	input  logic               arst_n,
	dqp_byte_if.sink           bytes,
	input  logic               fire,
	output logic               valid_s1,
	output dqp_pkg::beat_t     beat_s1
);

	logic accept;

	assign bytes.ready = !valid_s1 || fire;
	assign accept = bytes.valid && bytes.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			beat_s1.data_byte <= bytes.data_byte;
			beat_s1.last_byte <= bytes.last_byte;
		end
	end

endmodule

>>> src/dqp_parse_core.sv
// Parse state and single-pass decode of one datagram byte.
module dqp_parse_core (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               valid_s1,
	input  dqp_pkg::beat_t     beat_s1,
	input  logic               out_free,
	output logic               fire,
	output logic               load,
	output dqp_pkg::res_t      res
);

	dqp_pkg::phase_t phase_q, phase_d;
	logic [3:0]  pos_q, pos_d, pos_inc;
	logic [15:0] hw_q [dqp_pkg::HDR_WORDS];
	logic [15:0] hw_d [dqp_pkg::HDR_WORDS];
	logic [15:0] qleft_q, qleft_d;
	logic [7:0]  label_q, label_d;
	logic        first_q, first_d;
	logic [31:0] tc_q, tc_d;
	logic        gen;
	logic [7:0]  b;
	logic [15:0] flags;

	assign b = beat_s1.data_byte;
	assign pos_inc = pos_q + 4'd1;
	assign fire = valid_s1 && (out_free || !gen);
	assign load = fire && gen;

	always_comb begin
		phase_d = phase_q;
		pos_d = pos_q;
		for (int i = 0; i < dqp_pkg::HDR_WORDS; i++) begin
			hw_d[i] = hw_q[i];
		end
		qleft_d = qleft_q;
		label_d = label_q;
		first_d = first_q;
		tc_d = tc_q;
		gen = 1'b0;
		res = '0;
		flags = hw_q[1];

		case (phase_q)
			dqp_pkg::PH_HEADER: begin
				for (int i = 0; i < dqp_pkg::HDR_WORDS; i++) begin
					if (pos_q[3:1] == 3'(i)) begin
						hw_d[i] = {hw_q[i][7:0], b};
					end
				end
				pos_d = pos_inc;
				if (pos_q == dqp_pkg::HDR_LAST_POS) begin
					pos_d = '0;
					gen = 1'b1;
					res.ident = hw_q[0];
					res.count = hw_q[2];
					res.is_response = flags[15];
					res.op_code = flags[14:11];
					res.authoritative = flags[10];
					res.truncated_flag = flags[9];
					res.recursion_desired = flags[8];
					res.recursion_available = flags[7];
					res.response_code = flags[3:0];
					if ((hw_q[3] | hw_q[4]) != 16'd0) begin
						res.kind = dqp_pkg::KIND_HDR_REJ;
						phase_d = dqp_pkg::PH_REJECTED;
					end else begin
						res.kind = dqp_pkg::KIND_HDR_OK;
						qleft_d = hw_q[2];
						first_d = 1'b1;
						phase_d = (hw_q[2] != 16'd0) ? dqp_pkg::PH_NAME_LEN
							: dqp_pkg::PH_FINISHED;
					end
				end
			end
			dqp_pkg::PH_NAME_LEN: begin
				if (b == 8'd0) begin
					phase_d = dqp_pkg::PH_TYPECLS;
					pos_d = '0;
					tc_d = '0;
				end else begin
					label_d = b;
					phase_d = dqp_pkg::PH_NAME_CHR;
					if (!first_q) begin
						gen = 1'b1;
						res.kind = dqp_pkg::KIND_NAME_CHR;
						res.character = dqp_pkg::DOT_CHAR;
					end
					first_d = 1'b0;
				end
			end
			dqp_pkg::PH_NAME_CHR: begin
				gen = 1'b1;
				res.kind = dqp_pkg::KIND_NAME_CHR;
				res.character = b;
				label_d = label_q - 8'd1;
				if (label_q == 8'd1) begin
					phase_d = dqp_pkg::PH_NAME_LEN;
				end
			end
			dqp_pkg::PH_TYPECLS: begin
				tc_d = {tc_q[23:0], b};
				pos_d = pos_inc;
				if (pos_q == dqp_pkg::TC_LAST_POS) begin
					pos_d = '0;
					gen = 1'b1;
					res.kind = dqp_pkg::KIND_Q_END;
					res.ident = tc_q[23:8];
					res.count = {tc_q[7:0], b};
					qleft_d = qleft_q - 16'd1;
					first_d = 1'b1;
					phase_d = (qleft_q != 16'd1) ? dqp_pkg::PH_NAME_LEN
						: dqp_pkg::PH_FINISHED;
				end
			end
			default: begin
			end
		endcase

		if (beat_s1.last_byte) begin
			res = '0;
			res.kind = (phase_d == dqp_pkg::PH_FINISHED || phase_d == dqp_pkg::PH_REJECTED)
				? dqp_pkg::KIND_DONE : dqp_pkg::KIND_TRUNC;
			res.final_res = 1'b1;
			gen = 1'b1;
			phase_d = dqp_pkg::PH_HEADER;
			pos_d = '0;
			for (int i = 0; i < dqp_pkg::HDR_WORDS; i++) begin
				hw_d[i] = '0;
			end
			qleft_d = '0;
			label_d = '0;
			first_d = 1'b1;
			tc_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= dqp_pkg::PH_HEADER;
			pos_q <= '0;
			for (int i = 0; i < dqp_pkg::HDR_WORDS; i++) begin
				hw_q[i] <= '0;
			end
			qleft_q <= '0;
			label_q <= '0;
			first_q <= 1'b1;
			tc_q <= '0;
		end else if (fire) begin
			phase_q <= phase_d;
			pos_q <= pos_d;
			for (int i = 0; i < dqp_pkg::HDR_WORDS; i++) begin
				hw_q[i] <= hw_d[i];
			end
			qleft_q <= qleft_d;
			label_q <= label_d;
			first_q <= first_d;
			tc_q <= tc_d;
		end
	end

endmodule

>>> src/dqp_out_stage.sv
// Result register driving the result channel.
module dqp_out_stage (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               load,
	input  dqp_pkg::res_t      res,
	output logic               out_free,
	dqp_res_if.source          results
);

	logic          valid_q;
	dqp_pkg::res_t res_q;

	assign out_free = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (results.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res;
		end
	end

	assign results.valid = valid_q;
	assign results.kind = res_q.kind;
	assign results.ident = res_q.ident;
	assign results.count = res_q.count;
	assign results.is_response = res_q.is_response;
	assign results.op_code = res_q.op_code;
	assign results.authoritative = res_q.authoritative;
	assign results.truncated_flag = res_q.truncated_flag;
	assign results.recursion_desired = res_q.recursion_desired;
	assign results.recursion_available = res_q.recursion_available;
	assign results.response_code = res_q.response_code;
	assign results.character = res_q.character;
	assign results.final_res = res_q.final_res;

endmodule

>>> src/dns_query_parser.sv
// DNS query parser top level: input register, parse core, result register.
// A byte waits in the input register; its result, if any, loads into the result register.
// Throughput: one byte per cycle unless stalled; each byte passes the parse core once.
// A waiting result holds back only the next byte that produces a result.
// Reset (arst_n low, asynchronous): empties both registers and returns to the header phase.
module dns_query_parser (
	input  logic        clk,
	input  logic        arst_n,
	dqp_byte_if.sink    bytes,
	dqp_res_if.source   results
);

	logic           valid_s1;
	dqp_pkg::beat_t beat_s1;
	logic           fire;
	logic           load;
	logic           out_free;
	dqp_pkg::res_t  res;

	dqp_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.bytes    (bytes),
		.fire     (fire),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1)
	);

	dqp_parse_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.valid_s1 (valid_s1),
		.beat_s1  (beat_s1),
		.out_free (out_free),
		.fire     (fire),
		.load     (load),
		.res      (res)
	);

	dqp_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.res      (res),
		.out_free (out_free),
		.results  (results)
	);

`ifndef SYNTHESIS
	a_last_gives_final: assert property (@(posedge clk) disable iff (!arst_n)
		fire && beat_s1.last_byte |-> load && res.final_res)
		else $error("last byte did not produce a final result");

	a_final_kind: assert property (@(posedge clk) disable iff (!arst_n)
		results.valid && results.final_res |->
			results.kind == dqp_pkg::KIND_DONE || results.kind == dqp_pkg::KIND_TRUNC)
		else $error("final result with wrong kind");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !fire |=> valid_s1 && $stable(beat_s1))
		else $error("input stage lost a stalled beat");
`endif

endmodule
